/* rtl/fmdq_pkg.sv */
// ----------------------------------------------------------------------------
// fmdq_pkg
// Shared types and constants for the filtered multicast packet queues.
// ----------------------------------------------------------------------------
`default_nettype none

package fmdq_pkg;

  typedef enum logic [2:0] {
    ACT_DISPATCH = 3'd0,
    ACT_FETCH    = 3'd1,
    ACT_CLEAR    = 3'd2,
    ACT_FILTER   = 3'd3,
    ACT_LIMIT    = 3'd4,
    ACT_RSVD5    = 3'd5,
    ACT_RSVD6    = 3'd6,
    ACT_RSVD7    = 3'd7
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DONE
  } st_e;

  // Message id entries also match on the low half of the id.
  localparam logic [31:0] MSG_LOW_MASK = 32'h0000_FFFF;
  // Result masks only show the first few clients.
  localparam int unsigned MASK_BITS = 4;

  typedef struct packed {
    act_e        action;
    logic [1:0]  client;
    logic [7:0]  category;
    logic [31:0] msg_id;
    logic [15:0] packet_handle;
    logic        pass_all;
    logic        entry_kind;
    logic [1:0]  entry_index;
    logic [31:0] entry_value;
    logic        entry_enable;
    logic [4:0]  new_limit;
  } item_t;

endpackage

`default_nettype wire

/* rtl/filtered_multicast_drop_oldest_queues_top.sv */
// ----------------------------------------------------------------------------
// filtered_multicast_drop_oldest_queues_top
// Per-client filtered descriptor queues with drop-oldest overflow.
// ----------------------------------------------------------------------------
// One item is taken at a time. Fetch, clear, filter write, limit set and the
// unused codes go from transfer to result through accept, execute and result
// load. A dispatch repeats the execute step for every client: the per-client
// record memory (head, fill, counters) has one read and one write port, so
// the dispatch sweeps the clients one per cycle, reading the next record
// while writing back the current one, and each matching client appends one
// descriptor through the single write port of the queue store. A result
// waits in the output register until taken; the next item is accepted once
// the result has been loaded there. No clearing pass is needed after reset.
`default_nettype none

module filtered_multicast_drop_oldest_queues_top #(
  parameter int unsigned NUM_CLIENTS    = 4,
  parameter int unsigned RING_DEPTH     = 16,
  parameter int unsigned FILTER_ENTRIES = 4,
  parameter int unsigned HANDLE_BITS    = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [1:0]  client_i,
  input  wire logic [7:0]  category_i,
  input  wire logic [31:0] msg_id_i,
  input  wire logic [15:0] packet_handle_i,
  input  wire logic        pass_all_i,
  input  wire logic        entry_kind_i,
  input  wire logic [1:0]  entry_index_i,
  input  wire logic [31:0] entry_value_i,
  input  wire logic        entry_enable_i,
  input  wire logic [4:0]  new_limit_i,

  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       match_mask_o,
  output logic [3:0]       drop_mask_o,
  output logic             fetch_valid_o,
  output logic [15:0]      fetched_handle_o,
  output logic [4:0]       queue_fill_o,
  output logic [31:0]      received_total_o,
  output logic [31:0]      dropped_total_o
);

  localparam int unsigned CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned HW = $clog2(RING_DEPTH);
  localparam int unsigned NW = $clog2(RING_DEPTH + 1);
  localparam int unsigned SD = NUM_CLIENTS * RING_DEPTH;
  localparam int unsigned AW = $clog2(SD);

  typedef struct packed {
    logic [HW-1:0] head;
    logic [NW-1:0] cnt;
    logic [31:0]   rx;
    logic [31:0]   dr;
  } rec_t;

  // state and item
  fmdq_pkg::st_e   state_q, state_d;
  fmdq_pkg::item_t item_q;
  logic [CW-1:0]   ptr_q, ptr_d;
  logic            accept;

  // memories
  logic [HANDLE_BITS-1:0] st_mem [SD];
  logic [HANDLE_BITS-1:0] st_rdata_q;
  logic                   st_we, st_re;
  logic [AW-1:0]          st_waddr, st_raddr;
  logic [HANDLE_BITS-1:0] st_wdata;

  rec_t                   rec_mem [NUM_CLIENTS];
  rec_t                   rec_rdata_q;
  logic                   rec_rd_vld_q;
  logic [NUM_CLIENTS-1:0] rec_vld_q;
  logic                   rec_we, rec_re;
  logic [CW-1:0]          rec_raddr;
  rec_t                   rec_wdata;

  // filters and limits
  logic [NW-1:0] lim_q   [NUM_CLIENTS];
  logic          all_q   [NUM_CLIENTS];
  logic          cat_vld_q [NUM_CLIENTS][FILTER_ENTRIES];
  logic [7:0]    cat_val_q [NUM_CLIENTS][FILTER_ENTRIES];
  logic          mid_vld_q [NUM_CLIENTS][FILTER_ENTRIES];
  logic [31:0]   mid_val_q [NUM_CLIENTS][FILTER_ENTRIES];

  // step results
  logic [3:0]    mmask_q, mmask_d, dmask_q, dmask_d;
  logic          fvalid_q, fvalid_d;
  logic [NW-1:0] sfill_q, sfill_d;
  logic [31:0]   srx_q, srx_d, sdr_q, sdr_d;

  // output register
  logic          out_valid_q, out_load;
  logic [3:0]    out_mmask_q, out_dmask_q;
  logic          out_fvalid_q;
  logic [15:0]   out_handle_q;
  logic [NW-1:0] out_fill_q;
  logic [31:0]   out_rx_q, out_dr_q;

  // execute-stage helpers
  logic          ok;
  logic          last;
  logic          hit;
  logic          do_drop;
  rec_t          rec_cur, rec_new;
  logic [HW:0]   tail_sum;
  logic [HW-1:0] tail;
  logic [31:0]   mid_low;
  logic [NW-1:0] lim_set;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == fmdq_pkg::ST_IDLE);
  assign ok         = (32'(item_q.client) < NUM_CLIENTS);
  assign last       = (ptr_q == CW'(NUM_CLIENTS - 1));
  assign rec_cur    = rec_rd_vld_q ? rec_rdata_q : '0;
  assign mid_low    = item_q.msg_id & fmdq_pkg::MSG_LOW_MASK;

  // filter match for the client under ptr_q
  always_comb begin
    hit = all_q[ptr_q];
    for (int e = 0; e < FILTER_ENTRIES; e++) begin
      if (cat_vld_q[ptr_q][e] && cat_val_q[ptr_q][e] == item_q.category) hit = 1'b1;
      if (mid_vld_q[ptr_q][e] &&
          (mid_val_q[ptr_q][e] == item_q.msg_id || mid_val_q[ptr_q][e] == mid_low))
        hit = 1'b1;
    end
  end

  always_comb begin
    if (item_q.new_limit == '0) begin
      lim_set = NW'(1);
    end else if (32'(item_q.new_limit) > RING_DEPTH) begin
      lim_set = NW'(RING_DEPTH);
    end else begin
      lim_set = NW'(item_q.new_limit);
    end
  end

  // read-modify-write of the client record, queue store access
  always_comb begin
    rec_new  = rec_cur;
    do_drop  = 1'b0;
    st_we    = 1'b0;
    st_re    = 1'b0;
    st_raddr = AW'(ptr_q * RING_DEPTH) + AW'(rec_cur.head);
    rec_we   = 1'b0;
    mmask_d  = mmask_q;
    dmask_d  = dmask_q;
    fvalid_d = fvalid_q;
    sfill_d  = sfill_q;
    srx_d    = srx_q;
    sdr_d    = sdr_q;

    // drop-oldest and tail for a dispatch append
    if (rec_cur.cnt >= lim_q[ptr_q] && rec_cur.cnt != '0) do_drop = 1'b1;
    if (do_drop) begin
      rec_new.head = (rec_cur.head == HW'(RING_DEPTH - 1)) ? '0 : rec_cur.head + 1'b1;
      rec_new.cnt  = rec_cur.cnt - 1'b1;
      rec_new.dr   = rec_cur.dr + 32'd1;
    end
    tail_sum = (HW + 1)'(rec_new.head) + (HW + 1)'(rec_new.cnt);
    tail     = (32'(tail_sum) >= RING_DEPTH) ? HW'(tail_sum - (HW + 1)'(RING_DEPTH))
                                             : HW'(tail_sum);
    st_waddr = AW'(ptr_q * RING_DEPTH) + AW'(tail);
    st_wdata = HANDLE_BITS'(item_q.packet_handle);

    if (state_q == fmdq_pkg::ST_EXEC) begin
      if (item_q.action == fmdq_pkg::ACT_DISPATCH) begin
        if (hit) begin
          rec_new.cnt = rec_new.cnt + 1'b1;
          rec_new.rx  = rec_cur.rx + 32'd1;
          st_we       = 1'b1;
          rec_we      = 1'b1;
          for (int b = 0; b < fmdq_pkg::MASK_BITS; b++) begin
            if (32'(ptr_q) == b) begin
              mmask_d[b] = 1'b1;
              dmask_d[b] = do_drop;
            end
          end
        end else begin
          rec_new = rec_cur;
        end
        if (ok && ptr_q == CW'(item_q.client)) begin
          sfill_d = rec_new.cnt;
          srx_d   = rec_new.rx;
          sdr_d   = rec_new.dr;
        end
      end else begin
        rec_new = rec_cur;
        if (ok) begin
          unique case (item_q.action)
            fmdq_pkg::ACT_FETCH: begin
              if (rec_cur.cnt != '0) begin
                st_re        = 1'b1;
                fvalid_d     = 1'b1;
                rec_new.head = (rec_cur.head == HW'(RING_DEPTH - 1)) ? '0
                                                                     : rec_cur.head + 1'b1;
                rec_new.cnt  = rec_cur.cnt - 1'b1;
                rec_we       = 1'b1;
              end
            end
            fmdq_pkg::ACT_CLEAR: begin
              rec_new.cnt = '0;
              rec_we      = 1'b1;
            end
            default: ;
          endcase
          sfill_d = rec_new.cnt;
          srx_d   = rec_new.rx;
          sdr_d   = rec_new.dr;
        end
      end
    end
    rec_wdata = rec_new;
  end

  // next state and record read port
  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    rec_re    = 1'b0;
    rec_raddr = ptr_q + 1'b1;
    out_load  = 1'b0;
    unique case (state_q)
      fmdq_pkg::ST_IDLE: begin
        if (accept) begin
          ptr_d     = (fmdq_pkg::act_e'(action_i) == fmdq_pkg::ACT_DISPATCH) ? '0
                                                                             : CW'(client_i);
          rec_raddr = ptr_d;
          rec_re    = 1'b1;
          state_d   = fmdq_pkg::ST_EXEC;
        end
      end
      fmdq_pkg::ST_EXEC: begin
        if (item_q.action == fmdq_pkg::ACT_DISPATCH && !last) begin
          ptr_d  = ptr_q + 1'b1;
          rec_re = 1'b1;
        end else begin
          state_d = fmdq_pkg::ST_DONE;
        end
      end
      fmdq_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = fmdq_pkg::ST_IDLE;
        end
      end
      default: state_d = fmdq_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fmdq_pkg::ST_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.action        <= fmdq_pkg::act_e'(action_i);
      item_q.client        <= client_i;
      item_q.category      <= category_i;
      item_q.msg_id        <= msg_id_i;
      item_q.packet_handle <= packet_handle_i;
      item_q.pass_all      <= pass_all_i;
      item_q.entry_kind    <= entry_kind_i;
      item_q.entry_index   <= entry_index_i;
      item_q.entry_value   <= entry_value_i;
      item_q.entry_enable  <= entry_enable_i;
      item_q.new_limit     <= new_limit_i;
      mmask_q  <= '0;
      dmask_q  <= '0;
      fvalid_q <= 1'b0;
      sfill_q  <= '0;
      srx_q    <= '0;
      sdr_q    <= '0;
    end else begin
      mmask_q  <= mmask_d;
      dmask_q  <= dmask_d;
      fvalid_q <= fvalid_d;
      sfill_q  <= sfill_d;
      srx_q    <= srx_d;
      sdr_q    <= sdr_d;
    end
  end

  // queue store
  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (st_re) st_rdata_q <= st_mem[st_raddr];
  end

  // client records; a never-written record reads as zero
  always_ff @(posedge clk_i) begin
    if (rec_we) rec_mem[ptr_q] <= rec_wdata;
    if (rec_re) rec_rdata_q <= rec_mem[rec_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_vld_q    <= '0;
      rec_rd_vld_q <= 1'b0;
    end else begin
      if (rec_we) rec_vld_q[ptr_q] <= 1'b1;
      if (rec_re) rec_rd_vld_q <= rec_vld_q[rec_raddr];
    end
  end

  // filter flags and limits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLIENTS; c++) begin
        lim_q[c] <= NW'(RING_DEPTH);
        all_q[c] <= 1'b0;
        for (int e = 0; e < FILTER_ENTRIES; e++) begin
          cat_vld_q[c][e] <= 1'b0;
          mid_vld_q[c][e] <= 1'b0;
        end
      end
    end else if (state_q == fmdq_pkg::ST_EXEC && ok) begin
      if (item_q.action == fmdq_pkg::ACT_LIMIT) lim_q[ptr_q] <= lim_set;
      if (item_q.action == fmdq_pkg::ACT_FILTER) begin
        all_q[ptr_q] <= item_q.pass_all;
        for (int e = 0; e < FILTER_ENTRIES; e++) begin
          if (32'(item_q.entry_index) == e) begin
            if (item_q.entry_kind) mid_vld_q[ptr_q][e] <= item_q.entry_enable;
            else                   cat_vld_q[ptr_q][e] <= item_q.entry_enable;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == fmdq_pkg::ST_EXEC && ok && item_q.action == fmdq_pkg::ACT_FILTER) begin
      for (int e = 0; e < FILTER_ENTRIES; e++) begin
        if (32'(item_q.entry_index) == e) begin
          if (item_q.entry_kind) mid_val_q[ptr_q][e] <= item_q.entry_value;
          else                   cat_val_q[ptr_q][e] <= item_q.entry_value[7:0];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_mmask_q  <= mmask_q;
      out_dmask_q  <= dmask_q;
      out_fvalid_q <= fvalid_q;
      out_handle_q <= fvalid_q ? 16'(st_rdata_q) : '0;
      out_fill_q   <= sfill_q;
      out_rx_q     <= srx_q;
      out_dr_q     <= sdr_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign match_mask_o     = out_mmask_q;
  assign drop_mask_o      = out_dmask_q;
  assign fetch_valid_o    = out_fvalid_q;
  assign fetched_handle_o = out_handle_q;
  assign queue_fill_o     = 5'(out_fill_q);
  assign received_total_o = out_rx_q;
  assign dropped_total_o  = out_dr_q;

  // assertions
  a_drop_implies_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((drop_mask_o & ~match_mask_o) == 4'd0))
    else $error("drop reported for a client that did not take the packet");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_we |-> (32'(rec_wdata.cnt) <= RING_DEPTH))
    else $error("queue fill written above depth");

  a_store_write_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_we |-> (state_q == fmdq_pkg::ST_EXEC && item_q.action == fmdq_pkg::ACT_DISPATCH))
    else $error("queue store written outside a dispatch");

  a_fetch_no_masks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && fetch_valid_o) |-> (match_mask_o == 4'd0 && drop_mask_o == 4'd0))
    else $error("fetch result carries dispatch masks");

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == fmdq_pkg::ST_EXEC && item_q.action == fmdq_pkg::ACT_DISPATCH)
      |-> (32'(ptr_q) < NUM_CLIENTS))
    else $error("dispatch sweep pointer past the last client");

endmodule

`default_nettype wire
